// File: hw/rtl/bsm_pkg.sv
// Package for the bouncing sprite motion block.
// Holds screen walls, field widths, register indexes and the velocity helpers.
// No dependencies.
package bsm_pkg;

  localparam int VEL_W     = 20;
  localparam int GRAV_W    = 16;
  localparam int DAMP_W    = 9;
  localparam int COLOR_W   = 16;
  localparam int PIX_X_W   = 11;
  localparam int PIX_Y_W   = 9;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 20;
  localparam int DAMP_SHIFT = 8;

  localparam int WALL_X_LO   = 40;
  localparam int WALL_X_HI   = 1240;
  localparam int WALL_Y_LO   = 20;
  localparam int WALL_Y_HI   = 460;
  localparam int START_X_PIX = 640;

  // width of the raw damped product and of the values fed to saturation
  localparam int PROD_W = VEL_W + DAMP_W + 1;
  localparam int WIDE_W = VEL_W + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_POS_X = 4'd0,
    REG_START_POS_Y = 4'd1,
    REG_START_VEL_X = 4'd2,
    REG_START_VEL_Y = 4'd3,
    REG_GRAVITY_X   = 4'd4,
    REG_GRAVITY_Y   = 4'd5,
    REG_DAMPING     = 4'd6,
    REG_RAND_COLOR  = 4'd7
  } cfg_reg_t;

  localparam logic signed [WIDE_W-1:0] VEL_MAX_W = WIDE_W'(524287);
  localparam logic signed [WIDE_W-1:0] VEL_MIN_W = -WIDE_W'(524288);

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [WIDE_W-1:0] v);
    logic signed [VEL_W-1:0] r;
    if (v > VEL_MAX_W) begin
      r = VEL_MAX_W[VEL_W-1:0];
    end else if (v < VEL_MIN_W) begin
      r = VEL_MIN_W[VEL_W-1:0];
    end else begin
      r = v[VEL_W-1:0];
    end
    return r;
  endfunction

  // -v * damping / 256, truncated toward zero, then saturated
  function automatic logic signed [VEL_W-1:0] bounce(input logic signed [VEL_W-1:0] v,
                                                     input logic [DAMP_W-1:0] d);
    logic signed [DAMP_W:0]            ds;
    logic signed [PROD_W-1:0]          p;
    logic signed [PROD_W-DAMP_SHIFT-1:0] t;
    logic signed [WIDE_W-1:0]          n;
    ds = $signed({1'b0, d});
    p  = v * ds;
    t  = p[PROD_W-1:DAMP_SHIFT];
    if (p[PROD_W-1] && (p[DAMP_SHIFT-1:0] != '0)) begin
      t = t + (PROD_W-DAMP_SHIFT)'(1);
    end
    n = -WIDE_W'(t);
    return sat_vel(n);
  endfunction

endpackage

// File: hw/rtl/bouncing_sprite_motion.sv
// Bouncing sprite motion: one tick word in, one position/colour word out.
// Each tick word goes to the input register, then its result to the result register.
// Throughput 1 word per cycle unless out_stall; the single-pass update sets the rate.
// Synchronous active-low reset loads the start registers' reset values into
// position and velocity and clears the colour.
module bouncing_sprite_motion #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bsm_pkg::COLOR_W-1:0]         in_random_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bsm_pkg::PIX_X_W-1:0]         out_pixel_x,
  output logic [bsm_pkg::PIX_Y_W-1:0]         out_pixel_y,
  output logic [bsm_pkg::COLOR_W-1:0]         out_ball_color,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsm_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import bsm_pkg::*;

  // position must hold the far wall in fixed point, and at least the start word
  localparam int HI_BITS = $clog2(WALL_X_HI * (1 << FRAC_BITS) + 1) + 1;
  localparam int POS_W   = (HI_BITS > VEL_W) ? HI_BITS : VEL_W;
  localparam int SUM_W   = POS_W + 1;

  localparam logic signed [SUM_W-1:0] X_LO = SUM_W'(WALL_X_LO * (1 << FRAC_BITS));
  localparam logic signed [SUM_W-1:0] X_HI = SUM_W'(WALL_X_HI * (1 << FRAC_BITS));
  localparam logic signed [SUM_W-1:0] Y_LO = SUM_W'(WALL_Y_LO * (1 << FRAC_BITS));
  localparam logic signed [SUM_W-1:0] Y_HI = SUM_W'(WALL_Y_HI * (1 << FRAC_BITS));
  localparam logic signed [POS_W-1:0] START_X_RST = POS_W'(START_X_PIX * (1 << FRAC_BITS));

  // configuration
  logic signed [GRAV_W-1:0] grav_x_r, grav_y_r;
  logic [DAMP_W-1:0]        damp_r;
  logic                     rand_en_r;

  // motion state
  logic signed [POS_W-1:0]  pos_x_r, pos_y_r, pos_x_nxt, pos_y_nxt;
  logic signed [VEL_W-1:0]  vel_x_r, vel_y_r, vel_x_nxt, vel_y_nxt;
  logic [COLOR_W-1:0]       color_r, color_nxt;

  // input stage and result stage
  logic                     in_vld_r;
  logic [COLOR_W-1:0]       rnd_r;
  logic                     out_vld_r;
  logic [PIX_X_W-1:0]       pix_x_r;
  logic [PIX_Y_W-1:0]       pix_y_r;
  logic [COLOR_W-1:0]       out_color_r;

  logic                     out_free, advance, in_take;

  logic signed [VEL_W-1:0]  vx_g, vy_g;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic                     hit_x_hi, hit_x_lo, hit_y_hi, hit_y_lo;

  assign out_free  = !out_vld_r || !out_stall;
  assign advance   = in_vld_r && out_free;
  assign in_stall  = in_vld_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    vx_g  = sat_vel(WIDE_W'(vel_x_r) + WIDE_W'(grav_x_r));
    vy_g  = sat_vel(WIDE_W'(vel_y_r) + WIDE_W'(grav_y_r));
    sum_x = SUM_W'(pos_x_r) + SUM_W'(vx_g);
    sum_y = SUM_W'(pos_y_r) + SUM_W'(vy_g);

    hit_y_hi = sum_y > Y_HI;
    hit_y_lo = sum_y < Y_LO;
    hit_x_hi = sum_x > X_HI;
    hit_x_lo = sum_x < X_LO;

    pos_x_nxt = sum_x[POS_W-1:0];
    vel_x_nxt = vx_g;
    if (hit_x_hi) begin
      pos_x_nxt = X_HI[POS_W-1:0];
    end else if (hit_x_lo) begin
      pos_x_nxt = X_LO[POS_W-1:0];
    end
    if (hit_x_hi || hit_x_lo) begin
      vel_x_nxt = bounce(vx_g, damp_r);
    end

    pos_y_nxt = sum_y[POS_W-1:0];
    vel_y_nxt = vy_g;
    if (hit_y_hi) begin
      pos_y_nxt = Y_HI[POS_W-1:0];
    end else if (hit_y_lo) begin
      pos_y_nxt = Y_LO[POS_W-1:0];
    end
    if (hit_y_hi || hit_y_lo) begin
      vel_y_nxt = bounce(vy_g, damp_r);
    end

    color_nxt = color_r;
    if (hit_x_hi || hit_x_lo || hit_y_hi || hit_y_lo) begin
      color_nxt = rand_en_r ? rnd_r : '0;
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_x_r  <= '0;
      grav_y_r  <= '0;
      damp_r    <= DAMP_W'(256);
      rand_en_r <= 1'b0;
      pos_x_r   <= START_X_RST;
      pos_y_r   <= '0;
      vel_x_r   <= '0;
      vel_y_r   <= '0;
      color_r   <= '0;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
        vel_x_r <= vel_x_nxt;
        vel_y_r <= vel_y_nxt;
        color_r <= color_nxt;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_START_POS_X: pos_x_r   <= POS_W'($signed(cfg_data[VEL_W-1:0]));
          REG_START_POS_Y: pos_y_r   <= POS_W'($signed(cfg_data[VEL_W-1:0]));
          REG_START_VEL_X: vel_x_r   <= $signed(cfg_data[VEL_W-1:0]);
          REG_START_VEL_Y: vel_y_r   <= $signed(cfg_data[VEL_W-1:0]);
          REG_GRAVITY_X:   grav_x_r  <= $signed(cfg_data[GRAV_W-1:0]);
          REG_GRAVITY_Y:   grav_y_r  <= $signed(cfg_data[GRAV_W-1:0]);
          REG_DAMPING:     damp_r    <= cfg_data[DAMP_W-1:0];
          REG_RAND_COLOR:  rand_en_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload words
  always_ff @(posedge clk) begin
    if (in_take) begin
      rnd_r <= in_random_value;
    end
    if (advance) begin
      pix_x_r     <= pos_x_nxt[FRAC_BITS +: PIX_X_W];
      pix_y_r     <= pos_y_nxt[FRAC_BITS +: PIX_Y_W];
      out_color_r <= color_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_pixel_x    = pix_x_r;
  assign out_pixel_y    = pix_y_r;
  assign out_ball_color = out_color_r;

endmodule

// File: test/bouncing_sprite_motion_test.sv
// Self-checking testbench for bouncing_sprite_motion: random-gap tick driver, stalling
// result monitor and an in-bench sprite predictor fed at every accepted tick word.
// Depends on bsm_pkg and the bouncing_sprite_motion RTL only.
module bouncing_sprite_motion_test;
  import bsm_pkg::*;

  localparam int FRAC         = 8;
  localparam int HOLD_AT      = 350;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SHOWN_MAX    = 100;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_TICKS  = 150;
  localparam int MAX_WAIT     = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd8;
  localparam longint VEL_TOP    = (longint'(1) <<< (VEL_W - 1)) - 1;
  localparam longint VEL_BOTTOM = -(longint'(1) <<< (VEL_W - 1));

  typedef struct packed {
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic [COLOR_W-1:0] ball_color;
  } sprite_pos_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [COLOR_W-1:0]   in_random_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_X_W-1:0]   out_pixel_x;
  logic [PIX_Y_W-1:0]   out_pixel_y;
  logic [COLOR_W-1:0]   out_ball_color;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  logic [COLOR_W-1:0] tick_q[$];
  sprite_pos_t        expected_pos_q[$];
  sprite_pos_t        head_pos;

  // predicted sprite state and settings
  longint             spr_px, spr_py, spr_vx, spr_vy;
  logic [COLOR_W-1:0] spr_color;
  longint             acc_x, acc_y;
  logic [DAMP_W-1:0]  damp_k;
  logic               rand_colour_on;

  int  mismatch_count = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  int  tx_gap = 0;
  int  rx_wait = 0;
  int  rx_hold = 0;
  bit  steady_phase = 1'b0;

  bouncing_sprite_motion #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_random_value(in_random_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y), .out_ball_color(out_ball_color),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint clip_vel(longint v);
    if (v > VEL_TOP) return VEL_TOP;
    if (v < VEL_BOTTOM) return VEL_BOTTOM;
    return v;
  endfunction

  function automatic longint wall_at(int pix);
    return longint'(pix) <<< FRAC;
  endfunction

  // negate and scale, truncating toward zero
  function automatic longint rebound(longint v);
    longint q;
    q = -v * longint'(damp_k);
    if (q < 0) q = -((-q) >>> DAMP_SHIFT);
    else q = q >>> DAMP_SHIFT;
    return clip_vel(q);
  endfunction

  function automatic logic [COLOR_W-1:0] hit_colour(logic [COLOR_W-1:0] rnd);
    return rand_colour_on ? rnd : '0;
  endfunction

  function automatic void reset_sprite();
    spr_px         = wall_at(START_X_PIX);
    spr_py         = 0;
    spr_vx         = 0;
    spr_vy         = 0;
    spr_color      = '0;
    acc_x          = 0;
    acc_y          = 0;
    damp_k         = DAMP_W'(1 << DAMP_SHIFT);
    rand_colour_on = 1'b0;
  endfunction

  function automatic void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    case (idx)
      REG_START_POS_X: spr_px = longint'($signed(d));
      REG_START_POS_Y: spr_py = longint'($signed(d));
      REG_START_VEL_X: spr_vx = longint'($signed(d));
      REG_START_VEL_Y: spr_vy = longint'($signed(d));
      REG_GRAVITY_X:   acc_x = longint'($signed(d[GRAV_W-1:0]));
      REG_GRAVITY_Y:   acc_y = longint'($signed(d[GRAV_W-1:0]));
      REG_DAMPING:     damp_k = d[DAMP_W-1:0];
      REG_RAND_COLOR:  rand_colour_on = d[0];
      default: ;
    endcase
  endfunction

  // one tick: y walls before x walls, every hit recolours
  function automatic sprite_pos_t advance_sprite(logic [COLOR_W-1:0] rnd);
    sprite_pos_t r;
    spr_vy = clip_vel(spr_vy + acc_y);
    spr_vx = clip_vel(spr_vx + acc_x);
    spr_px = spr_px + spr_vx;
    spr_py = spr_py + spr_vy;
    if (spr_py > wall_at(WALL_Y_HI)) begin
      spr_py    = wall_at(WALL_Y_HI);
      spr_vy    = rebound(spr_vy);
      spr_color = hit_colour(rnd);
    end
    if (spr_py < wall_at(WALL_Y_LO)) begin
      spr_py    = wall_at(WALL_Y_LO);
      spr_vy    = rebound(spr_vy);
      spr_color = hit_colour(rnd);
    end
    if (spr_px > wall_at(WALL_X_HI)) begin
      spr_px    = wall_at(WALL_X_HI);
      spr_vx    = rebound(spr_vx);
      spr_color = hit_colour(rnd);
    end
    if (spr_px < wall_at(WALL_X_LO)) begin
      spr_px    = wall_at(WALL_X_LO);
      spr_vx    = rebound(spr_vx);
      spr_color = hit_colour(rnd);
    end
    r.pixel_x    = PIX_X_W'(spr_px >>> FRAC);
    r.pixel_y    = PIX_Y_W'(spr_py >>> FRAC);
    r.ball_color = spr_color;
    return r;
  endfunction

  function automatic int draw_wait();
    if (steady_phase) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < SHOWN_MAX) $display("ERROR result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  // tick word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_pos_q.push_back(advance_sprite(in_random_value));
        tx_gap = draw_wait();
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_valid        <= 1'b1;
          in_random_value <= tick_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor; one long hold-off lets the block back up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_pos_q.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          head_pos = expected_pos_q.pop_front();
          if (out_pixel_x !== head_pos.pixel_x)
            report_mismatch($sformatf("pixel_x got %0d expected %0d",
                                      out_pixel_x, head_pos.pixel_x));
          if (out_pixel_y !== head_pos.pixel_y)
            report_mismatch($sformatf("pixel_y got %0d expected %0d",
                                      out_pixel_y, head_pos.pixel_y));
          if (out_ball_color !== head_pos.ball_color)
            report_mismatch($sformatf("ball_color got %h expected %h",
                                      out_ball_color, head_pos.ball_color));
        end
        rx_wait = draw_wait();
        if (results_seen == HOLD_AT) rx_hold = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    load_register(idx, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) tick_q.push_back(COLOR_W'($urandom));
  endtask

  // idle point: every tick taken and every result word back
  task automatic settle();
    while (tick_q.size() != 0 || in_valid || expected_pos_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_setup(input int p);
    logic [CFG_DAT_W-1:0] d;
    int                   damp_v;
    d = ($urandom_range(0, 4) == 0) ? CFG_DAT_W'($urandom)
        : {4'($urandom), 16'($urandom_range(0, 128) - 64)};
    cfg_write(REG_GRAVITY_X, d);
    d = ($urandom_range(0, 4) == 0) ? CFG_DAT_W'($urandom)
        : {4'($urandom), 16'($urandom_range(0, 128) - 64)};
    cfg_write(REG_GRAVITY_Y, d);
    case (p % 4)
      0: damp_v = 1 << DAMP_SHIFT;
      1: damp_v = 0;
      2: damp_v = (1 << DAMP_W) - 1;
      default: damp_v = $urandom_range(0, 1) ? $urandom_range(192, 256)
                                             : $urandom_range(0, (1 << DAMP_W) - 1);
    endcase
    cfg_write(REG_DAMPING, {11'($urandom), 9'(damp_v)});
    cfg_write(REG_RAND_COLOR, CFG_DAT_W'($urandom));
    d = ($urandom_range(0, 4) == 0) ? CFG_DAT_W'($urandom)
        : CFG_DAT_W'(wall_at($urandom_range(WALL_X_LO, WALL_X_HI)) + $urandom_range(0, 255));
    cfg_write(REG_START_POS_X, d);
    d = ($urandom_range(0, 4) == 0) ? CFG_DAT_W'($urandom)
        : CFG_DAT_W'(wall_at($urandom_range(WALL_Y_LO, WALL_Y_HI)) + $urandom_range(0, 255));
    cfg_write(REG_START_POS_Y, d);
    d = ($urandom_range(0, 4) == 0) ? CFG_DAT_W'($urandom)
        : CFG_DAT_W'(longint'($urandom_range(0, 8192)) - 4096);
    cfg_write(REG_START_VEL_X, d);
    d = ($urandom_range(0, 4) == 0) ? CFG_DAT_W'($urandom)
        : CFG_DAT_W'(longint'($urandom_range(0, 8192)) - 4096);
    cfg_write(REG_START_VEL_Y, d);
    if ($urandom_range(0, 2) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, (1 << CFG_IDX_W) - 1)),
                CFG_DAT_W'($urandom));
  endtask

  initial begin
    reset_sprite();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: start y is above the top wall, so the first tick clamps
    tick_q.push_back(16'h0000);
    tick_q.push_back(16'hFFFF);
    tick_q.push_back(16'h1234);
    settle();

    // extreme starts, both axes hit on one tick, bounce of the most negative velocity
    cfg_write(REG_RAND_COLOR, 20'h00001);
    cfg_write(REG_START_POS_X, 20'h80000);
    cfg_write(REG_START_POS_Y, 20'h7FFFF);
    cfg_write(REG_START_VEL_X, 20'h7FFFF);
    cfg_write(REG_START_VEL_Y, 20'h80000);
    cfg_write(REG_GRAVITY_X, 20'h07FFF);
    cfg_write(REG_GRAVITY_Y, 20'h08000);
    cfg_write(REG_DAMPING, 20'h00100);
    tick_q.push_back(16'hFFFF);
    tick_q.push_back(16'h0000);
    tick_q.push_back(16'h5A5A);
    tick_q.push_back(16'hA5A5);
    push_ticks(2);
    settle();

    // damping above unity with saturation, colour off, spare indexes ignored
    cfg_write(REG_DAMPING, 20'h001FF);
    cfg_write(REG_RAND_COLOR, 20'hFFFFE);
    cfg_write(REG_GRAVITY_X, 20'hF8000);
    cfg_write(REG_GRAVITY_Y, 20'hF7FFF);
    cfg_write(REG_START_VEL_X, 20'd300000);
    cfg_write(REG_START_VEL_Y, 20'hB0000);
    for (int i = REG_SPARE_FIRST; i < (1 << CFG_IDX_W); i++)
      cfg_write(CFG_IDX_W'(i), CFG_DAT_W'($urandom));
    push_ticks(6);
    settle();

    // resting exactly on a wall is no hit; zero damping kills the bounce
    cfg_write(REG_DAMPING, 20'h00000);
    cfg_write(REG_RAND_COLOR, 20'h00001);
    cfg_write(REG_GRAVITY_X, 20'h00000);
    cfg_write(REG_GRAVITY_Y, 20'h00000);
    cfg_write(REG_START_POS_X, CFG_DAT_W'(wall_at(WALL_X_LO)));
    cfg_write(REG_START_POS_Y, CFG_DAT_W'(wall_at(WALL_Y_HI)));
    cfg_write(REG_START_VEL_X, 20'h00000);
    cfg_write(REG_START_VEL_Y, 20'h00000);
    push_ticks(2);
    settle();
    cfg_write(REG_GRAVITY_Y, 20'h00001);
    push_ticks(3);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      random_setup(p);
      steady_phase = (p % 3 == 1);
      push_ticks(PHASE_TICKS);
      settle();
      steady_phase = 1'b0;
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
